// ----- hw/rtl/mcc_pkg.sv -----
// shared types and constants for the minimum coin change block
// no dependencies
package mcc_pkg;

    localparam int AMT_W     = 10;
    localparam int CNT_W     = 10;
    localparam int COIN_W    = 10;
    localparam int COIN_REGS = 6;
    localparam int MAX_COINS = 6;
    localparam int NUM_W     = 3;
    localparam int IDX_W     = 3;
    localparam int DEPTH     = 1 << AMT_W;

    localparam logic [IDX_W-1:0] REG_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_COIN_0 = 3'd1;
    localparam logic [IDX_W-1:0] REG_COIN_5 = 3'd6;

    localparam logic [NUM_W-1:0] COINS_USABLE = NUM_W'(MAX_COINS < COIN_REGS ?
                                                       MAX_COINS : COIN_REGS);

    typedef logic [COIN_W-1:0] t_coin;

    typedef struct packed {
        logic [NUM_W-1:0]      count;
        t_coin [COIN_REGS-1:0] coin;
    } t_cfg;

    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] cnt;
    } t_entry;

endpackage

// ----- hw/rtl/mcc_cfg.sv -----
// configuration registers: coin count and six coin denominations
// depends on mcc_pkg
module mcc_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [9:0]           i_cfg_wdata,
    output mcc_pkg::t_cfg        o_cfg
);
    import mcc_pkg::*;

    t_cfg r_cfg;
    logic [IDX_W-1:0] coin_sel;

    assign coin_sel = i_cfg_idx - REG_COIN_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count   <= NUM_W'(5);
            r_cfg.coin[0] <= COIN_W'(5);
            r_cfg.coin[1] <= COIN_W'(10);
            r_cfg.coin[2] <= COIN_W'(25);
            r_cfg.coin[3] <= COIN_W'(50);
            r_cfg.coin[4] <= COIN_W'(100);
            r_cfg.coin[5] <= COIN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_COUNT) begin
                r_cfg.count <= i_cfg_wdata[NUM_W-1:0];
            end else if (i_cfg_idx <= REG_COIN_5) begin
                r_cfg.coin[coin_sel] <= i_cfg_wdata[COIN_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/mcc_ram.sv -----
// scratch table memory: one write port, one registered read port
// a read of the entry written in the same cycle returns the new data; depends on mcc_pkg
module mcc_ram (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [9:0]           i_waddr,
    input  mcc_pkg::t_entry      i_wdata,
    input  logic                 i_re,
    input  logic [9:0]           i_raddr,
    output mcc_pkg::t_entry      o_rdata
);
    import mcc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // write-first forwarding on the read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/min_coin_change_dp.sv -----
// minimum coin change, bottom-up table fill in one scratch memory
// depends on mcc_pkg, mcc_cfg, mcc_ram
//
// usage:
//   request: drive i_amount and raise start while busy is low; the request
//   is taken at that clock edge; busy, if raised, stays high until the result is out.
//   result: o_valid is high for exactly one cycle with o_min_coins and
//   o_reachable; the receiver cannot stall, so the result must be taken then.
//   config: i_cfg_we with i_cfg_idx (0 count, 1..6 coin 0..5) and
//   i_cfg_wdata, written only while busy is low; indexes above six are ignored.
//   the count is clamped to six; amount zero or a count of zero answers in
//   the next cycle and does not raise busy.
//   the table walk issues one memory read per coin per entry, so the single
//   read port sets the rate: one coin offer per cycle.
//   one request at a time; busy drops with o_valid, so the next request can
//   be taken at the edge that ends the o_valid cycle.
//   reset: synchronous active low, restores the default coins (count 5;
//   5, 10, 25, 50, 100, 1) and idles; the table needs no clearing since
//   every entry is rebuilt before it is read.
module min_coin_change_dp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  i_amount,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [9:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [9:0]  o_min_coins,
    output logic        o_reachable
);
    import mcc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    t_cfg cfg;

    logic             r_state;
    logic [AMT_W-1:0] r_amount;
    logic [NUM_W-1:0] r_n;
    logic [AMT_W-1:0] r_i;
    logic [NUM_W-1:0] r_j;
    logic             r_iss;

    // compare stage, in the cycle after the read issue
    logic             r_p_vld;
    logic             r_p_ok;
    logic             r_p_first;
    logic             r_p_last;
    logic [AMT_W-1:0] r_p_i;

    logic             r_best_vld;
    logic [CNT_W-1:0] r_best;

    logic             r_out_vld;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_reach;

    logic             accept;
    logic [NUM_W-1:0] n_eff;
    t_coin            coin;
    logic             coin_ok;
    logic [AMT_W-1:0] raddr;
    t_entry           rdata;

    logic             base_vld;
    logic [CNT_W-1:0] offer;
    logic             take;
    logic             n_best_vld;
    logic [CNT_W-1:0] n_best;

    logic             we;
    logic [AMT_W-1:0] waddr;
    t_entry           wdata;

    mcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign accept = start && !busy;
    assign n_eff  = (cfg.count > COINS_USABLE) ? COINS_USABLE : cfg.count;

    assign coin    = cfg.coin[r_j];
    assign coin_ok = (coin != '0) && (coin <= r_i);
    assign raddr   = r_i - coin;

    // fold the offer of the coin whose entry just came back
    assign base_vld = r_p_first ? 1'b0 : r_best_vld;
    assign offer    = rdata.cnt + CNT_W'(1);
    assign take     = r_p_ok && rdata.vld && (!base_vld || (offer < r_best));
    assign n_best_vld = take ? 1'b1 : base_vld;
    assign n_best     = take ? offer : r_best;

    // entry 0 is seeded when the request is taken
    assign we    = accept || (r_p_vld && r_p_last);
    assign waddr = accept ? '0 : r_p_i;
    always_comb begin
        if (accept) begin
            wdata.vld = 1'b1;
            wdata.cnt = '0;
        end else begin
            wdata.vld = n_best_vld;
            wdata.cnt = n_best;
        end
    end

    mcc_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (r_iss),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss     <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            r_p_vld   <= r_iss;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if ((i_amount == '0) || (n_eff == '0)) begin
                            r_out_vld <= 1'b1;
                        end else begin
                            r_state <= S_RUN;
                            r_iss   <= 1'b1;
                        end
                    end
                end
                S_RUN: begin
                    if (r_iss && (r_j == r_n - NUM_W'(1)) && (r_i == r_amount)) begin
                        r_iss <= 1'b0;
                    end
                    if (r_p_vld && r_p_last && (r_p_i == r_amount)) begin
                        r_state   <= S_IDLE;
                        r_out_vld <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_iss   <= 1'b0;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_amount    <= i_amount;
            r_n         <= n_eff;
            r_i         <= AMT_W'(1);
            r_j         <= '0;
            r_out_cnt   <= '0;
            r_out_reach <= (i_amount == '0);
        end else if (r_iss) begin
            if (r_j == r_n - NUM_W'(1)) begin
                r_j <= '0;
                r_i <= r_i + AMT_W'(1);
            end else begin
                r_j <= r_j + NUM_W'(1);
            end
        end
        r_p_ok    <= coin_ok;
        r_p_first <= (r_j == '0);
        r_p_last  <= (r_j == r_n - NUM_W'(1));
        r_p_i     <= r_i;
        if (r_p_vld) begin
            r_best_vld <= n_best_vld;
            r_best     <= n_best;
            if (r_p_last && (r_p_i == r_amount)) begin
                r_out_cnt   <= n_best_vld ? n_best : '0;
                r_out_reach <= n_best_vld;
            end
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_out_vld;
    assign o_min_coins = r_out_cnt;
    assign o_reachable = r_out_reach;

endmodule
